[design/rgb2i_pkg.sv]
// ----------------------------------------------------------------------------
// rgb2i_pkg
// Shared types, codes and constants for the RGB to I420 overlay block.
// ----------------------------------------------------------------------------
package rgb2i_pkg;

    // Default geometry
    localparam int OVERLAY_SIZE_DFLT = 64;
    localparam int FRAME_WIDTH_DFLT  = 352;
    localparam int FRAME_HEIGHT_DFLT = 288;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y = 1'b1;

    // Request modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_VIDEO = 1'b1;

    // Plane codes
    localparam logic [1:0] PLANE_LUMA = 2'd0;
    localparam logic [1:0] PLANE_U    = 2'd1;
    localparam logic [1:0] PLANE_V    = 2'd2;

    // BT.601 coefficients, Q16
    localparam logic [15:0] COEF_R = 16'd19595;
    localparam logic [15:0] COEF_G = 16'd38470;
    localparam logic [15:0] COEF_B = 16'd7471;
    localparam logic [15:0] COEF_U = 16'd36977;
    localparam logic [15:0] COEF_V = 16'd46728;

    // 127.5 in Q32, added before the chroma shift
    localparam logic signed [42:0] CHROMA_BIAS = 43'sd547608330240;

    typedef logic [7:0] t_pix;
    typedef logic [9:0] t_coord;

    // Write enables toward the overlay memories
    typedef struct packed {
        logic luma_we;
        logic chroma_we;
    } t_store_ctl;

    // Address width for a depth, at least one bit
    function automatic int clog2_min1(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

[design/rgb2i_in_if.sv]
// ----------------------------------------------------------------------------
// rgb2i_in_if
// Input channel: overlay pixel loads and video samples.
// ----------------------------------------------------------------------------
interface rgb2i_in_if;
    import rgb2i_pkg::*;

    logic   valid;
    logic   ready;
    logic   mode;
    t_pix   red;
    t_pix   green;
    t_pix   blue;
    t_coord row;
    t_coord col;
    logic [1:0] plane;
    t_pix   sample;

    modport source (
        output valid, mode, red, green, blue, row, col, plane, sample,
        input  ready
    );

    modport sink (
        input  valid, mode, red, green, blue, row, col, plane, sample,
        output ready
    );
endinterface

[design/rgb2i_out_if.sv]
// ----------------------------------------------------------------------------
// rgb2i_out_if
// Output channel: video samples after overlay replacement.
// ----------------------------------------------------------------------------
interface rgb2i_out_if;
    import rgb2i_pkg::*;

    logic valid;
    logic ready;
    t_pix pixel_out;

    modport source (
        output valid, pixel_out,
        input  ready
    );

    modport sink (
        input  valid, pixel_out,
        output ready
    );
endinterface

[design/rgb2i_conv.sv]
// ----------------------------------------------------------------------------
// rgb2i_conv
// Three-stage BT.601 color conversion: Q16 products, luma sum, chroma
// products; the chroma bias and clamp follow the last register.
// ----------------------------------------------------------------------------
module rgb2i_conv (
    input  logic          i_clk,
    input  logic          i_en,
    input  rgb2i_pkg::t_pix i_red,
    input  rgb2i_pkg::t_pix i_green,
    input  rgb2i_pkg::t_pix i_blue,
    output rgb2i_pkg::t_pix o_luma,
    output rgb2i_pkg::t_pix o_u,
    output rgb2i_pkg::t_pix o_v
);
    import rgb2i_pkg::*;

    logic [23:0]        r_s1_pr, r_s1_pg, r_s1_pb;
    t_pix               r_s1_red, r_s1_blue;
    logic [23:0]        r_s2_y16;
    t_pix               r_s2_red, r_s2_blue;
    t_pix               r_s3_luma;
    logic signed [41:0] r_s3_mu, r_s3_mv;

    logic signed [24:0] w_du, w_dv;
    logic signed [41:0] n_s3_mu, n_s3_mv;
    logic signed [42:0] w_su, w_sv;

    // Chroma differences and Q16 products
    always_comb begin
        w_du    = $signed({1'b0, r_s2_blue, 16'b0}) - $signed({1'b0, r_s2_y16});
        w_dv    = $signed({1'b0, r_s2_red, 16'b0}) - $signed({1'b0, r_s2_y16});
        n_s3_mu = 42'(w_du) * 42'($signed({1'b0, COEF_U}));
        n_s3_mv = 42'(w_dv) * 42'($signed({1'b0, COEF_V}));
    end

    // Advance the conversion pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_pr   <= 24'(i_red) * 24'(COEF_R);
            r_s1_pg   <= 24'(i_green) * 24'(COEF_G);
            r_s1_pb   <= 24'(i_blue) * 24'(COEF_B);
            r_s1_red  <= i_red;
            r_s1_blue <= i_blue;
            r_s2_y16  <= r_s1_pr + r_s1_pg + r_s1_pb;
            r_s2_red  <= r_s1_red;
            r_s2_blue <= r_s1_blue;
            r_s3_luma <= r_s2_y16[23:16];
            r_s3_mu   <= n_s3_mu;
            r_s3_mv   <= n_s3_mv;
        end
    end

    // Add the bias, shift and clamp to 0..255
    always_comb begin
        w_su = 43'(r_s3_mu) + CHROMA_BIAS;
        w_sv = 43'(r_s3_mv) + CHROMA_BIAS;
        if (w_su[42]) begin
            o_u = '0;
        end else if (|w_su[41:40]) begin
            o_u = '1;
        end else begin
            o_u = w_su[39:32];
        end
        if (w_sv[42]) begin
            o_v = '0;
        end else if (|w_sv[41:40]) begin
            o_v = '1;
        end else begin
            o_v = w_sv[39:32];
        end
    end

    assign o_luma = r_s3_luma;

endmodule

[design/rgb2i_store.sv]
// ----------------------------------------------------------------------------
// rgb2i_store
// Single-port overlay memories for luma, U and V with registered reads.
// ----------------------------------------------------------------------------
module rgb2i_store #(
    parameter  int OVERLAY_SIZE = rgb2i_pkg::OVERLAY_SIZE_DFLT,
    localparam int HALF_SIZE    = OVERLAY_SIZE / 2,
    localparam int LUMA_DEPTH   = OVERLAY_SIZE * OVERLAY_SIZE,
    localparam int CHROMA_DEPTH = HALF_SIZE * HALF_SIZE,
    localparam int LAW          = rgb2i_pkg::clog2_min1(LUMA_DEPTH),
    localparam int CAW          = rgb2i_pkg::clog2_min1(CHROMA_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  rgb2i_pkg::t_store_ctl i_ctl,
    input  logic [LAW-1:0]        i_luma_addr,
    input  logic [CAW-1:0]        i_chroma_addr,
    input  rgb2i_pkg::t_pix       i_luma,
    input  rgb2i_pkg::t_pix       i_u,
    input  rgb2i_pkg::t_pix       i_v,
    output rgb2i_pkg::t_pix       o_luma,
    output rgb2i_pkg::t_pix       o_u,
    output rgb2i_pkg::t_pix       o_v
);
    import rgb2i_pkg::*;

    t_pix mem_luma [LUMA_DEPTH];
    t_pix mem_u    [CHROMA_DEPTH];
    t_pix mem_v    [CHROMA_DEPTH];

    t_pix r_q_luma, r_q_u, r_q_v;

    // Write on loads, read old data on every advance
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ctl.luma_we) begin
                mem_luma[i_luma_addr] <= i_luma;
            end
            r_q_luma <= mem_luma[i_luma_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ctl.chroma_we) begin
                mem_u[i_chroma_addr] <= i_u;
            end
            r_q_u <= mem_u[i_chroma_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ctl.chroma_we) begin
                mem_v[i_chroma_addr] <= i_v;
            end
            r_q_v <= mem_v[i_chroma_addr];
        end
    end

    assign o_luma = r_q_luma;
    assign o_u    = r_q_u;
    assign o_v    = r_q_v;

endmodule

[design/rgb_to_i420_overlay.sv]
// ----------------------------------------------------------------------------
// rgb_to_i420_overlay: BT.601 RGB overlay keyed onto an I420 sample stream.
// A video sample passes stages s1 to s4 and then the output register; loads give no output.
// Throughput: one request per cycle; the whole pipeline holds while the output waits.
// Memories are single port and written/read in the same stage, so order is kept.
// Reset clears pos_x, pos_y and all valid flags; overlay memories are not cleared.
// ----------------------------------------------------------------------------
module rgb_to_i420_overlay #(
    parameter int OVERLAY_SIZE = rgb2i_pkg::OVERLAY_SIZE_DFLT,
    parameter int FRAME_WIDTH  = rgb2i_pkg::FRAME_WIDTH_DFLT,
    parameter int FRAME_HEIGHT = rgb2i_pkg::FRAME_HEIGHT_DFLT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rgb2i_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rgb2i_pkg::CFG_W-1:0]     i_cfg_data,
    rgb2i_in_if.sink                        i_in,
    rgb2i_out_if.source                     o_out
);
    import rgb2i_pkg::*;

    localparam int HALF_SIZE    = OVERLAY_SIZE / 2;
    localparam int LUMA_DEPTH   = OVERLAY_SIZE * OVERLAY_SIZE;
    localparam int CHROMA_DEPTH = HALF_SIZE * HALF_SIZE;
    localparam int LOW          = clog2_min1(OVERLAY_SIZE);
    localparam int HOW          = clog2_min1(HALF_SIZE);
    localparam int LAW          = clog2_min1(LUMA_DEPTH);
    localparam int CAW          = clog2_min1(CHROMA_DEPTH);

    localparam logic signed [11:0] SIZE_S  = 12'(OVERLAY_SIZE);
    localparam logic signed [11:0] HALF_S  = 12'(HALF_SIZE);
    localparam logic [10:0]        SIZE_U  = 11'(OVERLAY_SIZE);
    localparam logic [10:0]        HALF_U  = 11'(HALF_SIZE);
    localparam logic [10:0]        FW      = 11'(FRAME_WIDTH);
    localparam logic [10:0]        FH      = 11'(FRAME_HEIGHT);
    localparam logic [10:0]        FW_HALF = 11'(FRAME_WIDTH / 2);
    localparam logic [10:0]        FH_HALF = 11'(FRAME_HEIGHT / 2);

    // Configuration
    logic signed [10:0] r_pos_x, r_pos_y;

    // Pipeline control
    logic w_en;
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_out_valid;

    // Pipeline payload
    logic           r_s1_mode, r_s2_mode, r_s3_mode, r_s4_mode;
    logic [1:0]     r_s1_plane, r_s2_plane, r_s3_plane, r_s4_plane;
    t_pix           r_s1_sample, r_s2_sample, r_s3_sample, r_s4_sample;
    logic           r_s1_hit, r_s2_hit, r_s3_hit, r_s4_hit;
    logic           r_s1_lwe, r_s2_lwe, r_s3_lwe;
    logic           r_s1_cwe, r_s2_cwe, r_s3_cwe;
    logic [LOW-1:0] r_s1_ly, r_s1_lx;
    logic [HOW-1:0] r_s1_cy, r_s1_cx;
    logic [LAW-1:0] r_s2_laddr, r_s3_laddr;
    logic [CAW-1:0] r_s2_caddr, r_s3_caddr;
    t_pix           r_pixel_out;

    // Accept-stage window logic
    logic signed [10:0] w_half_x, w_half_y;
    logic signed [11:0] w_ly, w_lx, w_cy, w_cx;
    logic               w_luma_in, w_chroma_in, w_load_ok, w_load_chroma;
    logic               n_s1_hit, n_s1_lwe, n_s1_cwe;
    logic [LOW-1:0]     n_s1_ly, n_s1_lx;
    logic [HOW-1:0]     n_s1_cy, n_s1_cx;

    // Memory side
    t_store_ctl w_store_ctl;
    t_pix       w_conv_luma, w_conv_u, w_conv_v;
    t_pix       w_q_luma, w_q_u, w_q_v;
    t_pix       n_pixel_out;

    // Hold the pipeline while a result waits untaken
    assign w_en        = !r_out_valid || o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_out_valid;
    assign o_out.pixel_out = r_pixel_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POS_X: r_pos_x <= $signed(i_cfg_data);
                CFG_POS_Y: r_pos_y <= $signed(i_cfg_data);
            endcase
        end
    end

    // Window offsets; chroma origin is the luma origin halved toward zero
    always_comb begin
        w_half_x = (r_pos_x + $signed({10'b0, r_pos_x[10]})) >>> 1;
        w_half_y = (r_pos_y + $signed({10'b0, r_pos_y[10]})) >>> 1;
        w_ly = $signed({2'b0, i_in.row}) - 12'(r_pos_y);
        w_lx = $signed({2'b0, i_in.col}) - 12'(r_pos_x);
        w_cy = $signed({2'b0, i_in.row}) - 12'(w_half_y);
        w_cx = $signed({2'b0, i_in.col}) - 12'(w_half_x);

        w_luma_in = ({1'b0, i_in.row} < FH) && ({1'b0, i_in.col} < FW) &&
                    (w_ly >= 12'sd0) && (w_ly < SIZE_S) &&
                    (w_lx >= 12'sd0) && (w_lx < SIZE_S);
        w_chroma_in = ({1'b0, i_in.row} < FH_HALF) && ({1'b0, i_in.col} < FW_HALF) &&
                      (w_cy >= 12'sd0) && (w_cy < HALF_S) &&
                      (w_cx >= 12'sd0) && (w_cx < HALF_S);

        w_load_ok = ({1'b0, i_in.row} < SIZE_U) && ({1'b0, i_in.col} < SIZE_U);
        w_load_chroma = w_load_ok && !i_in.row[0] && !i_in.col[0] &&
                        ({2'b0, i_in.row[9:1]} < HALF_U) &&
                        ({2'b0, i_in.col[9:1]} < HALF_U);
    end

    // Pick load position or video window position
    always_comb begin
        if (i_in.mode == MODE_LOAD) begin
            n_s1_ly  = i_in.row[LOW-1:0];
            n_s1_lx  = i_in.col[LOW-1:0];
            n_s1_cy  = i_in.row[HOW:1];
            n_s1_cx  = i_in.col[HOW:1];
            n_s1_lwe = w_load_ok;
            n_s1_cwe = w_load_chroma;
            n_s1_hit = 1'b0;
        end else begin
            n_s1_ly  = w_ly[LOW-1:0];
            n_s1_lx  = w_lx[LOW-1:0];
            n_s1_cy  = w_cy[HOW-1:0];
            n_s1_cx  = w_cx[HOW-1:0];
            n_s1_lwe = 1'b0;
            n_s1_cwe = 1'b0;
            priority if (i_in.plane == PLANE_LUMA) begin
                n_s1_hit = w_luma_in;
            end else if (i_in.plane == PLANE_U || i_in.plane == PLANE_V) begin
                n_s1_hit = w_chroma_in;
            end else begin
                n_s1_hit = 1'b0;
            end
        end
    end

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= i_in.valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid && (r_s4_mode == MODE_VIDEO);
        end
    end

    // Advance payload and form linear memory addresses
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_mode   <= i_in.mode;
            r_s1_plane  <= i_in.plane;
            r_s1_sample <= i_in.sample;
            r_s1_hit    <= n_s1_hit;
            r_s1_lwe    <= n_s1_lwe;
            r_s1_cwe    <= n_s1_cwe;
            r_s1_ly     <= n_s1_ly;
            r_s1_lx     <= n_s1_lx;
            r_s1_cy     <= n_s1_cy;
            r_s1_cx     <= n_s1_cx;

            r_s2_mode   <= r_s1_mode;
            r_s2_plane  <= r_s1_plane;
            r_s2_sample <= r_s1_sample;
            r_s2_hit    <= r_s1_hit;
            r_s2_lwe    <= r_s1_lwe;
            r_s2_cwe    <= r_s1_cwe;
            r_s2_laddr  <= LAW'(r_s1_ly) * LAW'(OVERLAY_SIZE) + LAW'(r_s1_lx);
            r_s2_caddr  <= CAW'(r_s1_cy) * CAW'(HALF_SIZE) + CAW'(r_s1_cx);

            r_s3_mode   <= r_s2_mode;
            r_s3_plane  <= r_s2_plane;
            r_s3_sample <= r_s2_sample;
            r_s3_hit    <= r_s2_hit;
            r_s3_lwe    <= r_s2_lwe;
            r_s3_cwe    <= r_s2_cwe;
            r_s3_laddr  <= r_s2_laddr;
            r_s3_caddr  <= r_s2_caddr;

            r_s4_mode   <= r_s3_mode;
            r_s4_plane  <= r_s3_plane;
            r_s4_sample <= r_s3_sample;
            r_s4_hit    <= r_s3_hit;

            r_pixel_out <= n_pixel_out;
        end
    end

    // Color conversion, aligned with stage 3
    rgb2i_conv u_conv (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_red   (i_in.red),
        .i_green (i_in.green),
        .i_blue  (i_in.blue),
        .o_luma  (w_conv_luma),
        .o_u     (w_conv_u),
        .o_v     (w_conv_v)
    );

    // Overlay memories: loads write, video samples read, both from stage 3
    assign w_store_ctl = '{luma_we:   r_s3_valid && r_s3_lwe,
                           chroma_we: r_s3_valid && r_s3_cwe};

    rgb2i_store #(
        .OVERLAY_SIZE (OVERLAY_SIZE)
    ) u_store (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_ctl         (w_store_ctl),
        .i_luma_addr   (r_s3_laddr),
        .i_chroma_addr (r_s3_caddr),
        .i_luma        (w_conv_luma),
        .i_u           (w_conv_u),
        .i_v           (w_conv_v),
        .o_luma        (w_q_luma),
        .o_u           (w_q_u),
        .o_v           (w_q_v)
    );

    // Replace the sample with the overlay value on a window hit
    always_comb begin
        n_pixel_out = r_s4_sample;
        if (r_s4_hit) begin
            unique case (r_s4_plane)
                PLANE_LUMA: n_pixel_out = w_q_luma;
                PLANE_U:    n_pixel_out = w_q_u;
                default:    n_pixel_out = w_q_v;
            endcase
        end
    end

`ifndef SYNTHESIS
    // Chroma is only written together with luma
    a_chroma_with_luma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_store_ctl.chroma_we |-> w_store_ctl.luma_we)
        else $error("chroma write without luma write");

    // Only video samples can hit the window, and they never write
    a_hit_is_video: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && (r_s3_hit || r_s3_lwe)) |->
        ((r_s3_hit && r_s3_mode == MODE_VIDEO && !r_s3_lwe) ||
         (!r_s3_hit && r_s3_mode == MODE_LOAD)))
        else $error("window hit or write on wrong request type");

    // No result is shown in the cycle after reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid after reset");
`endif

endmodule
